[sv/qvr_pkg.sv]
// Shared types, constants and width helpers for the quaternion vector rotator.
`default_nettype none

package qvr_pkg;

  localparam int COMP_W     = 32;
  localparam int PROD_W     = 2 * COMP_W;
  localparam int SUM1_W     = PROD_W + 2;
  localparam int LO_W       = COMP_W - 1;
  localparam int NUM_STAGES = 5;

  typedef logic signed [COMP_W-1:0] comp_t;

  localparam comp_t COMP_MAX = 32'sh7FFF_FFFF;
  localparam comp_t COMP_MIN = 32'sh8000_0000;

  // bit j set: subtract term j of that component
  localparam logic [3:0] NEG_T [4] = '{4'hE, 4'h8, 4'h2, 4'h4};
  localparam logic [3:0] NEG_R [4] = '{4'h0, 4'h5, 4'h9, 4'h3};

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctl_t;

  function automatic int t_width(input int frac_bits);
    int w;
    w = SUM1_W - frac_bits;
    return (w > COMP_W + 1) ? w : COMP_W + 1;
  endfunction

endpackage

`default_nettype wire

[sv/qvr_tprod.sv]
// First Hamilton product q*v: partial products, then signed sum, round and shift.
`default_nettype none

module qvr_tprod #(
  parameter int FRAC_BITS = 30,
  localparam int TXW = qvr_pkg::t_width(FRAC_BITS)
) (
  input  logic                clk_i,
  input  qvr_pkg::pipe_ctl_t  ctl_i,
  input  qvr_pkg::comp_t      rot_i [4],
  input  qvr_pkg::comp_t      vec_i [4],
  output qvr_pkg::comp_t      rot_o [4],
  output logic signed [TXW-1:0] t_o [4]
);

  localparam int PW = qvr_pkg::PROD_W;
  localparam int SW = qvr_pkg::SUM1_W;
  localparam logic signed [SW-1:0] HALF = SW'(1) <<< (FRAC_BITS - 1);

  logic signed [PW-1:0]  prod_d [4][4];
  logic signed [PW-1:0]  prod_q [4][4];
  qvr_pkg::comp_t        rot_a_q [4];
  qvr_pkg::comp_t        rot_b_q [4];
  logic signed [TXW-1:0] t_d [4];
  logic signed [TXW-1:0] t_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        prod_d[k][j] = PW'(rot_i[j]) * PW'(vec_i[2'(k ^ j)]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[0]) begin
      prod_q  <= prod_d;
      rot_a_q <= rot_i;
    end
  end

  always_comb begin
    logic signed [SW-1:0] acc;
    logic signed [SW-1:0] sh;
    for (int k = 0; k < 4; k++) begin
      acc = HALF;
      for (int j = 0; j < 4; j++) begin
        if (qvr_pkg::NEG_T[k][j]) begin
          acc = acc - SW'(prod_q[k][j]);
        end else begin
          acc = acc + SW'(prod_q[k][j]);
        end
      end
      sh     = acc >>> FRAC_BITS;
      t_d[k] = TXW'(sh);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[1]) begin
      t_q     <= t_d;
      rot_b_q <= rot_a_q;
    end
  end

  assign t_o   = t_q;
  assign rot_o = rot_b_q;

endmodule

`default_nettype wire

[sv/qvr_cprod.sv]
// Second product t*conj(q): split partial products, sums, round, shift and saturate.
`default_nettype none

module qvr_cprod #(
  parameter int FRAC_BITS = 30,
  localparam int TXW = qvr_pkg::t_width(FRAC_BITS)
) (
  input  logic                  clk_i,
  input  qvr_pkg::pipe_ctl_t    ctl_i,
  input  qvr_pkg::comp_t        rot_i [4],
  input  logic signed [TXW-1:0] t_i [4],
  output qvr_pkg::comp_t        out_o [4]
);

  localparam int LW    = qvr_pkg::LO_W;
  localparam int CW    = qvr_pkg::COMP_W;
  localparam int PW    = qvr_pkg::PROD_W;
  localparam int HI_W  = TXW - LW;
  localparam int PH_W  = HI_W + CW;
  localparam int HS_W  = PH_W + 2;
  localparam int LS_W  = PW + 2;
  localparam int SUM_W = TXW + CW + 3;
  localparam logic signed [SUM_W-1:0] HALF    = SUM_W'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(qvr_pkg::COMP_MAX);
  localparam logic signed [SUM_W-1:0] SAT_MIN = SUM_W'(qvr_pkg::COMP_MIN);

  logic signed [PW-1:0]   plo_d [4][4];
  logic signed [PW-1:0]   plo_q [4][4];
  logic signed [PH_W-1:0] phi_d [4][4];
  logic signed [PH_W-1:0] phi_q [4][4];
  logic signed [HS_W-1:0] hsum_d [4];
  logic signed [HS_W-1:0] hsum_q [4];
  logic signed [LS_W-1:0] lsum_d [4];
  logic signed [LS_W-1:0] lsum_q [4];
  qvr_pkg::comp_t         out_d [4];
  qvr_pkg::comp_t         out_q [4];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      for (int j = 0; j < 4; j++) begin
        plo_d[k][j] = PW'($signed({1'b0, t_i[j][LW-1:0]})) * PW'(rot_i[2'(k ^ j)]);
        phi_d[k][j] = PH_W'($signed(t_i[j][TXW-1:LW])) * PH_W'(rot_i[2'(k ^ j)]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[2]) begin
      plo_q <= plo_d;
      phi_q <= phi_d;
    end
  end

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      hsum_d[k] = '0;
      lsum_d[k] = '0;
      for (int j = 0; j < 4; j++) begin
        if (qvr_pkg::NEG_R[k][j]) begin
          hsum_d[k] = hsum_d[k] - HS_W'(phi_q[k][j]);
          lsum_d[k] = lsum_d[k] - LS_W'(plo_q[k][j]);
        end else begin
          hsum_d[k] = hsum_d[k] + HS_W'(phi_q[k][j]);
          lsum_d[k] = lsum_d[k] + LS_W'(plo_q[k][j]);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[3]) begin
      hsum_q <= hsum_d;
      lsum_q <= lsum_d;
    end
  end

  always_comb begin
    logic signed [SUM_W-1:0] full;
    logic signed [SUM_W-1:0] sh;
    for (int k = 0; k < 4; k++) begin
      full = (SUM_W'(hsum_q[k]) <<< LW) + SUM_W'(lsum_q[k]) + HALF;
      sh   = full >>> FRAC_BITS;
      if (sh > SAT_MAX) begin
        out_d[k] = qvr_pkg::COMP_MAX;
      end else if (sh < SAT_MIN) begin
        out_d[k] = qvr_pkg::COMP_MIN;
      end else begin
        out_d[k] = $signed(sh[CW-1:0]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en[4]) begin
      out_q <= out_d;
    end
  end

  assign out_o = out_q;

endmodule

`default_nettype wire

[sv/quaternion_vector_rotate.sv]
// Top level of the quaternion vector rotator: r = q * v * conj(q), Q1.30 in and out.
//
// Input channel: in_valid_i with the quaternion (rot_*) and vector (vec_*)
// fields; a transaction completes on a clock edge with in_valid_i high and
// in_stall_o low. Output channel: out_valid_o with out_w/x/y/z; a transaction
// completes on an edge with out_valid_o high and out_stall_i low.
// Five register stages: q*v partial products, q*v sum and round, t*conj(q)
// split partial products, partial sums, then round, shift and saturate.
// out_valid_o rises once the transaction reaches the last stage register; one
// transaction per cycle is taken for as long as the receiver does not stall,
// the rate being set by 48 multipliers (16 in the first stage, 32 in the
// third), none of them shared between transactions.
// Stall handling: each stage holds while it is full and the stage after it
// holds, so empty stages keep filling and in_stall_o rises only when all five
// stages are full and out_stall_i is high. Nothing is dropped or repeated.
// Reset clears all stage valid bits; the datapath registers are not reset.
// Results round to nearest (ties upward) and saturate to the 32-bit range.
`default_nettype none

module quaternion_vector_rotate #(
  parameter int FRAC_BITS = 30
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [31:0]    rot_w_i,
  input  logic signed [31:0]    rot_x_i,
  input  logic signed [31:0]    rot_y_i,
  input  logic signed [31:0]    rot_z_i,
  input  logic signed [31:0]    vec_w_i,
  input  logic signed [31:0]    vec_x_i,
  input  logic signed [31:0]    vec_y_i,
  input  logic signed [31:0]    vec_z_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic signed [31:0]    out_w_o,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o,
  output logic signed [31:0]    out_z_o
);

  localparam int NS  = qvr_pkg::NUM_STAGES;
  localparam int TXW = qvr_pkg::t_width(FRAC_BITS);

  qvr_pkg::pipe_ctl_t    ctl;
  logic [NS-1:0]         valid_d;
  logic [NS-1:0]         valid_q;
  qvr_pkg::comp_t        rot_in [4];
  qvr_pkg::comp_t        vec_in [4];
  qvr_pkg::comp_t        rot_mid [4];
  logic signed [TXW-1:0] t_mid [4];
  qvr_pkg::comp_t        res [4];

  assign rot_in = '{rot_w_i, rot_x_i, rot_y_i, rot_z_i};
  assign vec_in = '{vec_w_i, vec_x_i, vec_y_i, vec_z_i};

  always_comb begin
    ctl.en[NS-1] = !valid_q[NS-1] || !out_stall_i;
    for (int s = NS - 2; s >= 0; s--) begin
      ctl.en[s] = !valid_q[s] || ctl.en[s+1];
    end
  end

  always_comb begin
    valid_d[0] = in_valid_i;
    for (int s = 1; s < NS; s++) begin
      valid_d[s] = valid_q[s-1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      for (int s = 0; s < NS; s++) begin
        if (ctl.en[s]) begin
          valid_q[s] <= valid_d[s];
        end
      end
    end
  end

  qvr_tprod #(
    .FRAC_BITS(FRAC_BITS)
  ) u_tprod (
    .clk_i(clk_i),
    .ctl_i(ctl),
    .rot_i(rot_in),
    .vec_i(vec_in),
    .rot_o(rot_mid),
    .t_o  (t_mid)
  );

  qvr_cprod #(
    .FRAC_BITS(FRAC_BITS)
  ) u_cprod (
    .clk_i(clk_i),
    .ctl_i(ctl),
    .rot_i(rot_mid),
    .t_i  (t_mid),
    .out_o(res)
  );

  assign in_stall_o  = !ctl.en[0];
  assign out_valid_o = valid_q[NS-1];
  assign out_w_o     = res[0];
  assign out_x_o     = res[1];
  assign out_y_o     = res[2];
  assign out_z_o     = res[3];

  a_stall_needs_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (&valid_q))
    else $error("input stalled while a pipeline stage is empty");

  a_no_stall_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled without downstream stall");

  a_held_stage_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q[NS-2] && !ctl.en[NS-2]) |=> valid_q[NS-2])
    else $error("held stage lost its transaction");

endmodule

`default_nettype wire
